FILE: src/dlesw_pkg.sv
// ----------------------------------------------------------------------------
// dlesw_pkg: shared types and constants of the DLE-framed receiver
// Link byte codes, result kinds, frame report codes and the command and
// status bundles that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package dlesw_pkg;

  // Link byte codes
  localparam logic [7:0] BYTE_STX   = 8'h02;
  localparam logic [7:0] BYTE_ETX   = 8'h03;
  localparam logic [7:0] BYTE_ACK   = 8'h06;
  localparam logic [7:0] BYTE_DLE   = 8'h10;
  localparam logic [7:0] BYTE_NAK   = 8'h15;
  localparam logic [7:0] BYTE_ALIVE = 8'h41;

  // Escape letters that follow a DLE inside a stuffed body
  localparam logic [7:0] ESC_DLE   = 8'h61;
  localparam logic [7:0] ESC_ACK   = 8'h62;
  localparam logic [7:0] ESC_NAK   = 8'h63;
  localparam logic [7:0] ESC_ALIVE = 8'h64;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_REPORT  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_CSUM_ERR  = 2'd2,
    ST_TOO_LONG  = 2'd3
  } frame_st_t;

  typedef enum logic [1:0] {
    SRC_PAYLOAD = 2'd0,
    SRC_ACK     = 2'd1,
    SRC_ALIVE   = 2'd2,
    SRC_REPORT  = 2'd3
  } out_src_t;

  typedef struct packed {
    logic     take;
    logic     tick;
    logic     scan_init;
    logic     seq_cap;
    logic     scan_step;
    logic     decide;
    logic     pay_init;
    logic     pay_adv;
    logic     frame_done;
    logic     out_load;
    out_src_t out_src;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic tick_fire;
    logic frame_end;
    logic scan_last;
    logic dec_accept;
    logic dec_ack;
    logic has_payload;
    logic pay_last;
  } dp_sts_t;

endpackage

FILE: src/dlesw_ctrl.sv
// ----------------------------------------------------------------------------
// dlesw_ctrl: frame sequencer
// Accepts transactions while idle and walks the end-of-frame pass: sequence
// capture, body scan, verdict, payload, ACK, keepalive and report.
// ----------------------------------------------------------------------------
module dlesw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               op,
  output logic               in_stall,
  input  dlesw_pkg::dp_sts_t sts,
  output dlesw_pkg::dp_cmd_t cmd
);
  import dlesw_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_SEQ      = 11'b000_0000_0010,
    S_SEQ_CAP  = 11'b000_0000_0100,
    S_SCAN_RD  = 11'b000_0000_1000,
    S_SCAN_USE = 11'b000_0001_0000,
    S_DECIDE   = 11'b000_0010_0000,
    S_PAY_RD   = 11'b000_0100_0000,
    S_PAY_OUT  = 11'b000_1000_0000,
    S_ACK      = 11'b001_0000_0000,
    S_ALIVE    = 11'b010_0000_0000,
    S_REPORT   = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          if (op == OP_TICK) begin
            cmd.tick = 1'b1;
            if (sts.tick_fire) begin
              cmd.out_load = 1'b1;
              cmd.out_src  = SRC_ALIVE;
              cmd.out_last = 1'b1;
            end
          end else begin
            cmd.take = 1'b1;
            if (sts.frame_end) begin
              cmd.scan_init = 1'b1;
              state_next    = S_SEQ;
            end
          end
        end
      end
      S_SEQ: begin
        state_next = S_SEQ_CAP;
      end
      S_SEQ_CAP: begin
        cmd.seq_cap = 1'b1;
        state_next  = sts.scan_last ? S_DECIDE : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_USE;
      end
      S_SCAN_USE: begin
        cmd.scan_step = 1'b1;
        state_next    = sts.scan_last ? S_DECIDE : S_SCAN_RD;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.dec_accept && sts.has_payload) begin
          cmd.pay_init = 1'b1;
          state_next   = S_PAY_RD;
        end else if (sts.dec_ack) begin
          state_next = S_ACK;
        end else begin
          state_next = S_ALIVE;
        end
      end
      S_PAY_RD: begin
        state_next = S_PAY_OUT;
      end
      S_PAY_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_PAYLOAD;
          cmd.pay_adv  = 1'b1;
          state_next   = sts.pay_last ? S_ACK : S_PAY_RD;
        end
      end
      S_ACK: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_ACK;
          state_next   = S_ALIVE;
        end
      end
      S_ALIVE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_ALIVE;
          state_next   = S_REPORT;
        end
      end
      S_REPORT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_src    = SRC_REPORT;
          cmd.out_last   = 1'b1;
          cmd.frame_done = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/dlesw_dp.sv
// ----------------------------------------------------------------------------
// dlesw_dp: receiver datapath
// Framer, raw frame store, unstuffing scan with checksum, body buffer,
// sequence state, keepalive timer and the registered result stage.
// ----------------------------------------------------------------------------
module dlesw_dp #(
  parameter int MAX_PAYLOAD = 16,
  parameter int MAX_FRAME   = 39
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic [7:0]         rx_byte,
  input  dlesw_pkg::dp_cmd_t cmd,
  output dlesw_pkg::dp_sts_t sts,
  input  logic               out_stall,
  output logic               out_valid,
  output dlesw_pkg::kind_t   out_kind,
  output logic [7:0]         out_value,
  output dlesw_pkg::frame_st_t out_status,
  output logic               out_last
);
  import dlesw_pkg::*;

  localparam int FS_AW   = $clog2(MAX_FRAME);
  localparam int RAW_W   = $clog2(MAX_FRAME + 1);
  localparam int BODY_N  = MAX_PAYLOAD + 1;
  localparam int BODY_AW = $clog2(BODY_N);
  localparam int LEN_W   = $clog2(BODY_N + 1);
  localparam logic [RAW_W-1:0] RAW_MAX  = RAW_W'(MAX_FRAME);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(BODY_N);

  typedef enum logic [3:0] {
    PH_HUNT     = 4'b0001,
    PH_GOT_DLE  = 4'b0010,
    PH_BODY     = 4'b0100,
    PH_BODY_DLE = 4'b1000
  } rx_phase_t;

  function automatic logic [7:0] ones8(input logic [7:0] v);
    logic [7:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c = c + {7'd0, v[k]};
    end
    return c;
  endfunction

  // Framer and frame store
  rx_phase_t        rx_phase;
  rx_phase_t        rx_phase_next;
  rx_phase_t        phase_eff;
  logic [RAW_W-1:0] raw_length;
  logic [RAW_W-1:0] raw_length_next;
  logic [RAW_W-1:0] len_eff;
  logic             bound_hit;
  logic             ignore;
  logic             fs_we;
  logic             frame_end;
  logic [7:0]       fs_mem [MAX_FRAME];
  logic [7:0]       fs_rdata;

  // Scan
  logic [RAW_W-1:0] scan_idx;
  logic             pend;
  logic             pend_next;
  logic             emit;
  logic [7:0]       emit_val;
  logic             is_esc;
  logic [7:0]       esc_val;
  logic [LEN_W-1:0] body_len;
  logic             too_long;
  logic [7:0]       cs;
  logic [7:0]       body0;
  logic [7:0]       seq;
  logic             body_we;
  logic [7:0]       body_mem [BODY_N];
  logic [7:0]       body_rdata;
  logic [LEN_W-1:0] pay_idx;

  // Sequence and verdict
  logic [7:0]       expected_seq;
  logic             seq_fresh;
  logic             nonempty;
  logic             dup;
  logic             cs_ok;
  logic [7:0]       base_seq;
  frame_st_t        dec_st;
  frame_st_t        frame_st;

  // Keepalive
  logic [15:0]      keepalive_period;
  logic [15:0]      tick_count;
  logic [16:0]      tick_sum;
  logic             tick_fire;

  logic             out_free;

  // --------------------------------------------------------------------------
  // Framer
  // --------------------------------------------------------------------------
  always_comb begin
    ignore          = (rx_byte == BYTE_ALIVE);
    bound_hit       = (raw_length >= RAW_MAX);
    len_eff         = bound_hit ? '0 : raw_length;
    phase_eff       = bound_hit ? PH_HUNT : rx_phase;
    fs_we           = 1'b0;
    frame_end       = 1'b0;
    raw_length_next = len_eff;
    rx_phase_next   = phase_eff;
    case (phase_eff)
      PH_HUNT: begin
        if (rx_byte == BYTE_DLE) begin
          fs_we           = 1'b1;
          raw_length_next = len_eff + RAW_W'(1);
          rx_phase_next   = PH_GOT_DLE;
        end
      end
      PH_GOT_DLE: begin
        if (rx_byte == BYTE_STX) begin
          fs_we           = 1'b1;
          raw_length_next = len_eff + RAW_W'(1);
          rx_phase_next   = PH_BODY;
        end else if (rx_byte != BYTE_DLE) begin
          raw_length_next = '0;
          rx_phase_next   = PH_HUNT;
        end
      end
      PH_BODY: begin
        fs_we           = 1'b1;
        raw_length_next = len_eff + RAW_W'(1);
        if (rx_byte == BYTE_DLE) begin
          rx_phase_next = PH_BODY_DLE;
        end
      end
      PH_BODY_DLE: begin
        if (rx_byte == BYTE_ETX) begin
          fs_we           = 1'b1;
          frame_end       = 1'b1;
          raw_length_next = len_eff + RAW_W'(1);
          rx_phase_next   = PH_HUNT;
        end else if (rx_byte == BYTE_STX) begin
          raw_length_next = RAW_W'(2);
          rx_phase_next   = PH_BODY;
        end else begin
          fs_we           = 1'b1;
          raw_length_next = len_eff + RAW_W'(1);
          rx_phase_next   = PH_BODY;
        end
      end
      default: begin
        raw_length_next = '0;
        rx_phase_next   = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase   <= PH_HUNT;
      raw_length <= '0;
    end else if (cmd.take && !ignore) begin
      rx_phase   <= rx_phase_next;
      raw_length <= raw_length_next;
    end else if (cmd.frame_done) begin
      raw_length <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && fs_we && !ignore) begin
      fs_mem[len_eff[FS_AW-1:0]] <= rx_byte;
    end
    fs_rdata <= fs_mem[scan_idx[FS_AW-1:0]];
  end

  // --------------------------------------------------------------------------
  // Unstuffing scan
  // --------------------------------------------------------------------------
  always_comb begin
    is_esc  = 1'b1;
    esc_val = BYTE_DLE;
    case (fs_rdata)
      ESC_DLE:   esc_val = BYTE_DLE;
      ESC_ACK:   esc_val = BYTE_ACK;
      ESC_NAK:   esc_val = BYTE_NAK;
      ESC_ALIVE: esc_val = BYTE_ALIVE;
      default:   is_esc  = 1'b0;
    endcase
    pend_next = 1'b0;
    emit      = 1'b0;
    emit_val  = fs_rdata;
    if (pend && is_esc) begin
      emit     = 1'b1;
      emit_val = esc_val;
    end else if (fs_rdata == BYTE_DLE) begin
      pend_next = 1'b1;
    end else begin
      emit = 1'b1;
    end
    body_we = cmd.scan_step && emit && (body_len != LEN_FULL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      pend     <= 1'b0;
      body_len <= '0;
      too_long <= 1'b0;
      pay_idx  <= '0;
    end else begin
      if (cmd.scan_init) begin
        scan_idx <= RAW_W'(2);
        pend     <= 1'b0;
        body_len <= '0;
        too_long <= 1'b0;
      end else if (cmd.seq_cap) begin
        scan_idx <= scan_idx + RAW_W'(1);
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + RAW_W'(1);
        pend     <= pend_next;
        if (emit) begin
          if (body_len != LEN_FULL) begin
            body_len <= body_len + LEN_W'(1);
          end else begin
            too_long <= 1'b1;
          end
        end
      end
      if (cmd.pay_init) begin
        pay_idx <= LEN_W'(1);
      end else if (cmd.pay_adv) begin
        pay_idx <= pay_idx + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cs <= '0;
    end else if (body_we && (body_len != '0)) begin
      cs <= cs + ones8(emit_val);
    end
    if (body_we && (body_len == '0)) begin
      body0 <= emit_val;
    end
    if (cmd.seq_cap) begin
      seq <= fs_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (body_we) begin
      body_mem[body_len[BODY_AW-1:0]] <= emit_val;
    end
    body_rdata <= body_mem[pay_idx[BODY_AW-1:0]];
  end

  // --------------------------------------------------------------------------
  // Verdict and alternating-bit state
  // --------------------------------------------------------------------------
  always_comb begin
    nonempty = (body_len != '0);
    dup      = !seq_fresh && (seq != expected_seq);
    cs_ok    = (cs == body0);
    base_seq = seq_fresh ? seq : expected_seq;
    if (too_long) begin
      dec_st = ST_TOO_LONG;
    end else if (!nonempty) begin
      dec_st = ST_CSUM_ERR;
    end else if (dup) begin
      dec_st = ST_DUPLICATE;
    end else if (!cs_ok) begin
      dec_st = ST_CSUM_ERR;
    end else begin
      dec_st = ST_ACCEPTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq <= '0;
      seq_fresh    <= 1'b1;
    end else if (cmd.decide && !too_long && nonempty) begin
      seq_fresh <= 1'b0;
      if (dec_st == ST_ACCEPTED) begin
        expected_seq <= (base_seq == '0) ? 8'd1 : 8'd0;
      end else if (seq_fresh) begin
        expected_seq <= seq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      frame_st <= dec_st;
    end
  end

  // --------------------------------------------------------------------------
  // Keepalive timer and period register
  // --------------------------------------------------------------------------
  assign tick_sum  = {1'b0, tick_count} + 17'd1;
  assign tick_fire = (tick_sum > {1'b0, keepalive_period});

  always_ff @(posedge clk) begin
    if (rst) begin
      keepalive_period <= 16'd3;
      tick_count       <= '0;
    end else begin
      if (cfg_we) begin
        keepalive_period <= cfg_wdata;
      end
      if (cmd.scan_init) begin
        tick_count <= '0;
      end else if (cmd.tick) begin
        tick_count <= tick_fire ? 16'd0 : tick_sum[15:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last <= cmd.out_last;
      case (cmd.out_src)
        SRC_PAYLOAD: begin
          out_kind   <= KIND_PAYLOAD;
          out_value  <= body_rdata;
          out_status <= ST_ACCEPTED;
        end
        SRC_ACK: begin
          out_kind   <= KIND_TX;
          out_value  <= BYTE_ACK;
          out_status <= ST_ACCEPTED;
        end
        SRC_REPORT: begin
          out_kind   <= KIND_REPORT;
          out_value  <= '0;
          out_status <= frame_st;
        end
        default: begin
          out_kind   <= KIND_TX;
          out_value  <= BYTE_ALIVE;
          out_status <= ST_ACCEPTED;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Status
  // --------------------------------------------------------------------------
  always_comb begin
    sts             = '0;
    sts.out_free    = out_free;
    sts.tick_fire   = tick_fire;
    sts.frame_end   = frame_end && !ignore;
    sts.scan_last   = ({1'b0, scan_idx} + (RAW_W+1)'(3)) >= {1'b0, raw_length};
    sts.dec_accept  = (dec_st == ST_ACCEPTED);
    sts.dec_ack     = (dec_st == ST_ACCEPTED) || (dec_st == ST_DUPLICATE);
    sts.has_payload = (body_len > LEN_W'(1));
    sts.pay_last    = ((pay_idx + LEN_W'(1)) == body_len);
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.out_load)
    else $error("result register loaded while its transaction is stalled");

  a_scan_in_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (({1'b0, scan_idx} + (RAW_W+1)'(3)) <= {1'b0, raw_length}))
    else $error("body scan ran past the closing DLE");

  a_too_long_full: assert property (@(posedge clk) disable iff (rst)
    too_long |-> (body_len == LEN_FULL))
    else $error("overlong body flagged before the buffer filled");

  a_pay_in_body: assert property (@(posedge clk) disable iff (rst)
    cmd.pay_adv |-> ((pay_idx != '0) && (pay_idx < body_len)))
    else $error("payload read outside the unstuffed body");
`endif

endmodule

FILE: src/dle_framed_stop_and_wait_receiver.sv
// ----------------------------------------------------------------------------
// dle_framed_stop_and_wait_receiver: DLE STX/ETX framed receiver
// Hunts for DLE STX, stores the raw frame up to DLE ETX, then unstuffs the
// body, checks the popcount checksum and the alternating sequence bit and
// answers with payload, ACK, keepalive and a frame report. Idle ticks send
// a keepalive byte once the programmed period has passed.
//
//   channel  | handshake           | fields
//   ---------+---------------------+--------------------------------------
//   config   | cfg_we              | cfg_wdata (keepalive_period)
//   input    | in_valid / in_stall | op, rx_byte
//   output   | out_valid/out_stall | kind, value, frame_status, last
//
// Ticks and bytes that do not close a frame are taken back to back while the
// result register is free.
// A closing ETX starts the end-of-frame pass: the sequence byte, each stored
// body byte (single read port on the frame store), the verdict, each payload
// byte of an accepted frame (body buffer read), an ACK for an accepted or
// duplicate frame, keepalive and report, with waits while the output stalls.
// Reset is synchronous; nothing is sent out of reset and the period is 3.
// The input stalls throughout the end-of-frame pass and whenever the result
// register holds a stalled transaction.
// ----------------------------------------------------------------------------
module dle_framed_stop_and_wait_receiver #(
  parameter int MAX_PAYLOAD = 16,
  parameter int MAX_FRAME   = 39
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  value,
  output logic [1:0]  frame_status,
  output logic        last
);
  import dlesw_pkg::*;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  kind_t     out_kind;
  frame_st_t out_status;

  // Sequencer: owns the handshake on the input side and steps the
  // end-of-frame pass one command at a time.
  dlesw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: framer, frame store, scan, body buffer, sequence state,
  // keepalive timer and the result register that drives the output side.
  dlesw_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .MAX_FRAME   (MAX_FRAME)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .rx_byte    (rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_kind   (out_kind),
    .out_value  (value),
    .out_status (out_status),
    .out_last   (last)
  );

  // Drive the plain output ports from the typed result fields.
  assign kind         = out_kind;
  assign frame_status = out_status;

endmodule
